@@ rtl/sdfgj_pkg.sv @@
package sdfgj_pkg;

   localparam int MAX_ORDER = 6;
   localparam int NCOLS     = MAX_ORDER + 1;
   localparam int DEPTH     = MAX_ORDER * NCOLS;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int IDX_W     = 3;
   localparam int ELEM_W    = 16;
   localparam int ACC_W     = 64;
   localparam int HALF_W    = ACC_W / 2;
   localparam int PROD_W    = 2 * ACC_W + 2;
   localparam int SH_W      = $clog2(ACC_W);
   localparam int LC_W      = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_ORDER_SIX    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIVOT_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RHS_SHIFT    = 2'd2;

   typedef logic signed [ACC_W-1:0] acc_type;
   typedef logic [ACC_W-1:0]        mag_type;
   typedef logic [ADDR_W-1:0]       addr_type;
   typedef logic [IDX_W-1:0]        idx_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
      acc_type  data;
   } wr_type;

   typedef struct packed {
      logic            start;
      logic [SH_W-1:0] sh;
   } cmb_ctl_type;

   function automatic addr_type mem_addr(input idx_type r, input idx_type c);
      logic [ADDR_W+IDX_W-1:0] a;
      a = (ADDR_W+IDX_W)'(r * NCOLS + c);
      return a[ADDR_W-1:0];
   endfunction

   function automatic mag_type mag(input acc_type v);
      return v[ACC_W-1] ? mag_type'(-v) : mag_type'(v);
   endfunction

   // row of a load position: count of whole rows below it
   function automatic idx_type load_row(input logic [LC_W-1:0] lc, input logic [3:0] np1);
      idx_type r;
      r = '0;
      for (int k = 1; k <= MAX_ORDER; k++) begin
         if ({4'd0, lc} >= 10'(k) * {6'd0, np1}) r = IDX_W'(k);
      end
      return r;
   endfunction

endpackage

@@ rtl/sdfgj_req_if.sv @@
interface sdfgj_req_if
   import sdfgj_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [ELEM_W-1:0] element_value;

   modport source (output valid, output element_value, input ready);
   modport sink   (input valid, input element_value, output ready);
endinterface

@@ rtl/sdfgj_rsp_if.sv @@
interface sdfgj_rsp_if
   import sdfgj_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [IDX_W-1:0]  row_index;
   acc_type           numerator;
   acc_type           denominator;
   logic              last_row;

   modport source (output valid, output row_index, output numerator,
                   output denominator, output last_row, input ready);
   modport sink   (input valid, input row_index, input numerator,
                   input denominator, input last_row, output ready);
endinterface

@@ rtl/sdfgj_store.sv @@
module sdfgj_store
   import sdfgj_pkg::*;
(
   input  logic     clock,
   input  wr_type   wr,
   input  addr_type rd_addr_a,
   input  addr_type rd_addr_b,
   output acc_type  rd_data_a,
   output acc_type  rd_data_b
);
   acc_type mem [DEPTH];
   acc_type rd_a_ff;
   acc_type rd_b_ff;

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr.en) mem[wr.addr] <= wr.data;
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
endmodule

@@ rtl/sdfgj_combine.sv @@
module sdfgj_combine
   import sdfgj_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmb_ctl_type ctl,
   input  acc_type     piv,
   input  acc_type     x,
   input  acc_type     lead,
   input  acc_type     y,
   output logic        done,
   output acc_type     result
);
   localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'({1'b0, {(ACC_W-1){1'b1}}});
   localparam logic signed [PROD_W-1:0] SAT_MIN = -SAT_MAX - PROD_W'(1);

   logic                     busy_ff, busy_in;
   logic [3:0]               cnt_ff, cnt_in;
   logic                     done_ff, done_in;
   mag_type                  ma_ff, mx_ff, ml_ff, my_ff;
   logic                     n1_ff, n2_ff;
   logic [SH_W-1:0]          sh_ff;
   logic [ACC_W-1:0]         pp_ff, pp_in;
   logic                     pv_ff, pv_in;
   logic                     pneg_ff, pneg_in;
   logic [1:0]               poff_ff, poff_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic signed [PROD_W-1:0] shr_ff, shr_in;
   acc_type                  res_ff, res_in;
   logic [HALF_W-1:0]        opa, opb;
   mag_type                  sa, sb;
   logic signed [PROD_W-1:0] term;

   // operand halves for the partial product of this step
   always_comb begin
      sa = cnt_ff[2] ? ml_ff : ma_ff;
      sb = cnt_ff[2] ? my_ff : mx_ff;
      opa = cnt_ff[1] ? sa[ACC_W-1:HALF_W] : sa[HALF_W-1:0];
      opb = cnt_ff[0] ? sb[ACC_W-1:HALF_W] : sb[HALF_W-1:0];
   end

   // weighted, signed partial product
   always_comb begin
      term = $signed({{(PROD_W-ACC_W){1'b0}}, pp_ff}) <<< (HALF_W * int'(poff_ff));
      if (pneg_ff) term = -term;
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      pp_in   = pp_ff;
      pv_in   = 1'b0;
      pneg_in = pneg_ff;
      poff_in = poff_ff;
      acc_in  = acc_ff;
      shr_in  = shr_ff;
      res_in  = res_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 4'd1;
         // one 32 by 32 product per cycle, eight in all
         if (!cnt_ff[3]) begin
            pp_in   = opa * opb;
            pv_in   = 1'b1;
            pneg_in = cnt_ff[2] ? n2_ff : n1_ff;
            poff_in = 2'(cnt_ff[1]) + 2'(cnt_ff[0]);
         end
         if (pv_ff) acc_in = acc_ff + term;
         // floor shift, then clamp
         if (cnt_ff == 4'd9) shr_in = acc_ff >>> sh_ff;
         if (cnt_ff == 4'd10) begin
            if (shr_ff > SAT_MAX)      res_in = acc_type'(SAT_MAX);
            else if (shr_ff < SAT_MIN) res_in = acc_type'(SAT_MIN);
            else                       res_in = shr_ff[ACC_W-1:0];
            done_in = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
         pv_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
         pv_ff   <= pv_in;
      end
   end

   // operand capture and datapath
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         ma_ff <= mag(piv);
         mx_ff <= mag(x);
         ml_ff <= mag(lead);
         my_ff <= mag(y);
         n1_ff <= piv[ACC_W-1] != x[ACC_W-1];
         n2_ff <= lead[ACC_W-1] == y[ACC_W-1];
         sh_ff <= ctl.sh;
      end
      pp_ff   <= pp_in;
      pneg_ff <= pneg_in;
      poff_ff <= poff_in;
      acc_ff  <= acc_in;
      shr_ff  <= shr_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule

@@ rtl/scaled_division_free_gauss_jordan.sv @@
// loading: one element per cycle while req.valid is high; the run starts after the
// last element; elimination updates n*(n-1)*(n+1) entries one at a time through the
// combine unit, plus pivot search, row swap and a pivot log2 per column
// output: each result passes read, capture and hold; hold waits on rsp.ready. The next
// system is taken after the last result, so the shared combine unit sets the pace
// reset: control and configuration cleared (order 4, pivoting on, shift 3);
// matrix memory is not cleared
module scaled_division_free_gauss_jordan
   import sdfgj_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   sdfgj_req_if.sink             req,
   sdfgj_rsp_if.source           rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_wdata
);
   typedef enum logic [16:0] {
      S_LOAD     = 17'h00001,
      S_SRCH_RD  = 17'h00002,
      S_SRCH_CMP = 17'h00004,
      S_SWAP_RD  = 17'h00008,
      S_SWAP_WA  = 17'h00010,
      S_SWAP_WB  = 17'h00020,
      S_PIV_RD   = 17'h00040,
      S_PIV_GET  = 17'h00080,
      S_PIV_SH   = 17'h00100,
      S_LEAD_RD  = 17'h00200,
      S_LEAD_GET = 17'h00400,
      S_ELEM_RD  = 17'h00800,
      S_ELEM_GO  = 17'h01000,
      S_ELEM_WT  = 17'h02000,
      S_OUT_RD   = 17'h04000,
      S_OUT_CAP  = 17'h08000,
      S_OUT_HOLD = 17'h10000
   } state_type;

   state_type        state_ff, state_in;
   logic             order_six_ff, order_six_in;
   logic             pivot_en_ff, pivot_en_in;
   logic [3:0]       rhs_shift_ff, rhs_shift_in;
   logic [LC_W-1:0]  lc_ff, lc_in;
   idx_type          n_ff, n_in;
   idx_type          k_ff, k_in;
   idx_type          i_ff, i_in;
   idx_type          j_ff, j_in;
   idx_type          best_ff, best_in;
   mag_type          bm_ff, bm_in;
   acc_type          tmp_ff, tmp_in;
   acc_type          piv_ff, piv_in;
   acc_type          lead_ff, lead_in;
   mag_type          t_ff, t_in;
   logic [SH_W-1:0]  sh_ff, sh_in;
   idx_type          oidx_ff, oidx_in;
   acc_type          onum_ff, onum_in;
   acc_type          oden_ff, oden_in;
   logic             olast_ff, olast_in;

   wr_type           wr;
   addr_type         rd_addr_a, rd_addr_b;
   acc_type          rd_data_a, rd_data_b;
   cmb_ctl_type      cmb_ctl;
   logic             cmb_done;
   acc_type          cmb_result;

   idx_type          cur_n, ld_row, ld_col, first_row, next_row;
   logic [3:0]       np1;
   logic [LC_W-1:0]  total, lc_next, ld_span;
   acc_type          ld_val;
   mag_type          cur_mag;

   sdfgj_store u_store (
      .clock     (clock),
      .wr        (wr),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   sdfgj_combine u_combine (
      .clock  (clock),
      .reset  (reset),
      .ctl    (cmb_ctl),
      .piv    (piv_ff),
      .x      (rd_data_a),
      .lead   (lead_ff),
      .y      (rd_data_b),
      .done   (cmb_done),
      .result (cmb_result)
   );

   // load position under the order in force
   always_comb begin
      cur_n   = order_six_ff ? IDX_W'(6) : IDX_W'(4);
      np1     = 4'(cur_n) + 4'd1;
      total   = LC_W'(cur_n) * LC_W'(np1);
      lc_next = lc_ff + LC_W'(1);
      ld_row  = load_row(lc_ff, np1);
      ld_span = LC_W'(ld_row) * LC_W'(np1);
      ld_col  = IDX_W'(lc_ff - ld_span);
      ld_val  = acc_type'(req.element_value);
      if (ld_col == cur_n) ld_val = ld_val <<< rhs_shift_ff;
      cur_mag = mag(rd_data_a);
   end

   // row walk skipping the pivot row
   always_comb begin
      first_row = (k_ff == '0) ? IDX_W'(1) : IDX_W'(0);
      next_row  = (i_ff + IDX_W'(1) == k_ff) ? i_ff + IDX_W'(2) : i_ff + IDX_W'(1);
   end

   // memory addressing
   always_comb begin
      rd_addr_a = mem_addr(i_ff, k_ff);
      rd_addr_b = mem_addr(i_ff, k_ff);
      case (state_ff)
         S_SWAP_RD: begin
            rd_addr_a = mem_addr(k_ff, j_ff);
            rd_addr_b = mem_addr(best_ff, j_ff);
         end
         S_PIV_RD: rd_addr_a = mem_addr(k_ff, k_ff);
         S_ELEM_RD: begin
            rd_addr_a = mem_addr(i_ff, j_ff);
            rd_addr_b = mem_addr(k_ff, j_ff);
         end
         S_OUT_RD: begin
            rd_addr_a = mem_addr(i_ff, n_ff);
            rd_addr_b = mem_addr(i_ff, i_ff);
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      order_six_in = order_six_ff;
      pivot_en_in  = pivot_en_ff;
      rhs_shift_in = rhs_shift_ff;
      lc_in        = lc_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      best_in      = best_ff;
      bm_in        = bm_ff;
      tmp_in       = tmp_ff;
      piv_in       = piv_ff;
      lead_in      = lead_ff;
      t_in         = t_ff;
      sh_in        = sh_ff;
      oidx_in      = oidx_ff;
      onum_in      = onum_ff;
      oden_in      = oden_ff;
      olast_in     = olast_ff;
      wr           = '{en: 1'b0, addr: mem_addr(i_ff, j_ff), data: cmb_result};
      cmb_ctl      = '{start: 1'b0, sh: sh_ff};

      // configuration writes
      if (csr_we) begin
         case (csr_index)
            CSR_ORDER_SIX:    order_six_in = csr_wdata[0];
            CSR_PIVOT_ENABLE: pivot_en_in  = csr_wdata[0];
            CSR_RHS_SHIFT:    rhs_shift_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_LOAD: begin
            if (req.valid) begin
               if (lc_ff < total) begin
                  wr = '{en: 1'b1, addr: mem_addr(ld_row, ld_col), data: ld_val};
               end
               if (lc_next == '0 || lc_next >= total) begin
                  lc_in = '0;
                  n_in  = cur_n;
                  k_in  = '0;
                  i_in  = '0;
                  state_in = pivot_en_ff ? S_SRCH_RD : S_PIV_RD;
               end else begin
                  lc_in = lc_next;
               end
            end
         end
         S_SRCH_RD: state_in = S_SRCH_CMP;
         S_SRCH_CMP: begin
            if (i_ff == k_ff || cur_mag > bm_ff) begin
               bm_in   = cur_mag;
               best_in = i_ff;
            end
            i_in = i_ff + IDX_W'(1);
            if (i_ff + IDX_W'(1) == n_ff) begin
               j_in = '0;
               if (i_ff == k_ff || cur_mag > bm_ff) begin
                  state_in = (i_ff != k_ff) ? S_SWAP_RD : S_PIV_RD;
               end else begin
                  state_in = (best_ff != k_ff) ? S_SWAP_RD : S_PIV_RD;
               end
            end else begin
               state_in = S_SRCH_RD;
            end
         end
         S_SWAP_RD: state_in = S_SWAP_WA;
         S_SWAP_WA: begin
            wr       = '{en: 1'b1, addr: mem_addr(k_ff, j_ff), data: rd_data_b};
            tmp_in   = rd_data_a;
            state_in = S_SWAP_WB;
         end
         S_SWAP_WB: begin
            wr   = '{en: 1'b1, addr: mem_addr(best_ff, j_ff), data: tmp_ff};
            j_in = j_ff + IDX_W'(1);
            state_in = (j_ff == n_ff) ? S_PIV_RD : S_SWAP_RD;
         end
         S_PIV_RD: state_in = S_PIV_GET;
         S_PIV_GET: begin
            piv_in   = rd_data_a;
            t_in     = cur_mag;
            sh_in    = '0;
            state_in = S_PIV_SH;
         end
         // floor log2 of the pivot magnitude, one bit a cycle
         S_PIV_SH: begin
            if (t_ff > mag_type'(1)) begin
               t_in  = t_ff >> 1;
               sh_in = sh_ff + SH_W'(1);
            end else begin
               i_in     = first_row;
               state_in = S_LEAD_RD;
            end
         end
         S_LEAD_RD: state_in = S_LEAD_GET;
         S_LEAD_GET: begin
            lead_in  = rd_data_a;
            j_in     = '0;
            state_in = S_ELEM_RD;
         end
         S_ELEM_RD: state_in = S_ELEM_GO;
         S_ELEM_GO: begin
            cmb_ctl.start = 1'b1;
            state_in      = S_ELEM_WT;
         end
         S_ELEM_WT: begin
            if (cmb_done) begin
               wr.en = 1'b1;
               j_in  = j_ff + IDX_W'(1);
               if (j_ff != n_ff) begin
                  state_in = S_ELEM_RD;
               end else if (next_row < n_ff) begin
                  i_in     = next_row;
                  state_in = S_LEAD_RD;
               end else if (k_ff + IDX_W'(1) == n_ff) begin
                  i_in     = '0;
                  state_in = S_OUT_RD;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  i_in     = k_ff + IDX_W'(1);
                  state_in = pivot_en_ff ? S_SRCH_RD : S_PIV_RD;
               end
            end
         end
         S_OUT_RD: state_in = S_OUT_CAP;
         S_OUT_CAP: begin
            oidx_in  = i_ff;
            onum_in  = rd_data_a;
            oden_in  = rd_data_b;
            olast_in = (i_ff + IDX_W'(1) == n_ff);
            state_in = S_OUT_HOLD;
         end
         S_OUT_HOLD: begin
            if (rsp.ready) begin
               i_in     = i_ff + IDX_W'(1);
               state_in = olast_ff ? S_LOAD : S_OUT_RD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         order_six_ff <= 1'b0;
         pivot_en_ff  <= 1'b1;
         rhs_shift_ff <= 4'd3;
         lc_ff        <= '0;
         n_ff         <= '0;
         k_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         order_six_ff <= order_six_in;
         pivot_en_ff  <= pivot_en_in;
         rhs_shift_ff <= rhs_shift_in;
         lc_ff        <= lc_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      best_ff  <= best_in;
      bm_ff    <= bm_in;
      tmp_ff   <= tmp_in;
      piv_ff   <= piv_in;
      lead_ff  <= lead_in;
      t_ff     <= t_in;
      sh_ff    <= sh_in;
      oidx_ff  <= oidx_in;
      onum_ff  <= onum_in;
      oden_ff  <= oden_in;
      olast_ff <= olast_in;
   end

   assign req.ready       = (state_ff == S_LOAD);
   assign rsp.valid       = (state_ff == S_OUT_HOLD);
   assign rsp.row_index   = oidx_ff;
   assign rsp.numerator   = onum_ff;
   assign rsp.denominator = oden_ff;
   assign rsp.last_row    = olast_ff;
endmodule
